// File: src/etdt_pkg.sv
// ----------------------------------------------------------------------------
// etdt_pkg
// Shared types and constants of the earliest-deadline timer table.
// ----------------------------------------------------------------------------
package etdt_pkg;

	// Fixed field widths.
	localparam int TIME_BITS = 63;
	localparam int OFF_BITS  = 4;
	localparam int REQ_BITS  = 2;
	localparam int ERR_BITS  = 3;

	// Line offset register value after reset (64-byte lines).
	localparam logic [OFF_BITS-1:0] OFF_RESET = 4'd6;

	// Request codes on the input channel; the unused codes act as queries.
	localparam logic [REQ_BITS-1:0] REQ_ARM    = 2'd1;
	localparam logic [REQ_BITS-1:0] REQ_DISARM = 2'd2;

	typedef enum logic [1:0] {
		OP_QUERY,
		OP_ARM,
		OP_DISARM
	} op_t;

	typedef enum logic [ERR_BITS-1:0] {
		ERR_OK         = 3'd0,
		ERR_MISALIGNED = 3'd1,
		ERR_ARMED      = 3'd2,
		ERR_NOT_ARMED  = 3'd3,
		ERR_FULL       = 3'd4
	} err_t;

	// Classification that the front end attaches to each queued request.
	typedef struct packed {
		op_t  op;
		logic misaligned;
	} cls_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_COMMIT,
		ST_RESULT
	} back_state_t;

endpackage

// File: src/etdt_if.sv
// ----------------------------------------------------------------------------
// etdt channel interfaces
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------

// Request channel: one beat carries one arm, disarm or query request.
interface etdt_req_if #(parameter int ADDR_BITS = 48);
	logic                           valid;
	logic                           ready;
	logic [etdt_pkg::REQ_BITS-1:0]  req_type;
	logic [ADDR_BITS-1:0]           line_address;
	logic [etdt_pkg::TIME_BITS-1:0] due_time;
	logic [etdt_pkg::TIME_BITS-1:0] cur_time;

	modport source (
		output valid, req_type, line_address, due_time, cur_time,
		input  ready
	);
	modport sink (
		input  valid, req_type, line_address, due_time, cur_time,
		output ready
	);
endinterface

// Response channel: one beat carries the result of one request.
interface etdt_rsp_if #(parameter int ADDR_BITS = 48);
	logic                          valid;
	logic                          ready;
	logic                          has_entry;
	logic                          is_ready;
	logic [ADDR_BITS-1:0]          next_address;
	logic                          wake_request;
	logic [etdt_pkg::ERR_BITS-1:0] error_code;

	modport source (
		output valid, has_entry, is_ready, next_address, wake_request, error_code,
		input  ready
	);
	modport sink (
		input  valid, has_entry, is_ready, next_address, wake_request, error_code,
		output ready
	);
endinterface

// File: src/etdt_fifo.sv
// ----------------------------------------------------------------------------
// etdt_fifo
// Two-entry queue between the request front end and the table engine.
// ----------------------------------------------------------------------------
module etdt_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full     = (count_q == (PTR_W+1)'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = slot_q[rd_ptr_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage for queued requests.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// File: src/etdt_front.sv
// ----------------------------------------------------------------------------
// etdt_front
// Holds the line offset register, decodes each request and checks alignment.
// ----------------------------------------------------------------------------
module etdt_front #(
	parameter int ADDR_BITS = 48,
	parameter int WORD_BITS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [etdt_pkg::OFF_BITS-1:0] cfg_data,
	etdt_req_if.sink                      req,
	input  logic                          fifo_full,
	output logic                          push,
	output logic [WORD_BITS-1:0]          push_data
);

	logic [etdt_pkg::OFF_BITS-1:0] off_q;
	logic [ADDR_BITS-1:0]          low_mask;
	etdt_pkg::cls_t                cls;

	// Line offset register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= etdt_pkg::OFF_RESET;
		end else if (cfg_we) begin
			off_q <= cfg_data;
		end
	end

	// Decode the request and flag an arm or disarm address with offset bits set.
	always_comb begin
		low_mask = ~({ADDR_BITS{1'b1}} << off_q);
		case (req.req_type)
			etdt_pkg::REQ_ARM:    cls.op = etdt_pkg::OP_ARM;
			etdt_pkg::REQ_DISARM: cls.op = etdt_pkg::OP_DISARM;
			default:              cls.op = etdt_pkg::OP_QUERY;
		endcase
		cls.misaligned = (cls.op != etdt_pkg::OP_QUERY) && (|(req.line_address & low_mask));
	end

	// A beat is taken whenever the queue has room.
	assign req.ready = !fifo_full;
	assign push      = req.valid && !fifo_full;
	assign push_data = {cls, req.line_address, req.due_time, req.cur_time};

endmodule

// File: src/etdt_back.sv
// ----------------------------------------------------------------------------
// etdt_back
// Table engine: slot memories, a one-slot-per-cycle scan that finds a match,
// the first free slot and the earliest remaining entry, then the update and
// the registered response.
// ----------------------------------------------------------------------------
module etdt_back #(
	parameter int TABLE_ENTRIES = 16,
	parameter int ADDR_BITS     = 48,
	parameter int WORD_BITS     = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fifo_empty,
	input  logic [WORD_BITS-1:0] pop_data,
	output logic                 pop,
	etdt_rsp_if.source           rsp
);

	localparam int TB       = etdt_pkg::TIME_BITS;
	localparam int CLS_BITS = $bits(etdt_pkg::cls_t);
	localparam int IDX_W    = $clog2(TABLE_ENTRIES);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

	// Fields of the queued request.
	etdt_pkg::cls_t       in_cls;
	logic [ADDR_BITS-1:0] in_addr;
	logic [TB-1:0]        in_rtime;
	logic [TB-1:0]        in_ctime;

	assign in_ctime = pop_data[TB-1:0];
	assign in_rtime = pop_data[2*TB-1:TB];
	assign in_addr  = pop_data[2*TB +: ADDR_BITS];
	assign in_cls   = etdt_pkg::cls_t'(pop_data[2*TB+ADDR_BITS +: CLS_BITS]);

	// Sequencer.
	etdt_pkg::back_state_t state_q, state_d;
	logic issue;
	logic commit;
	logic out_load;

	// Request being worked on.
	etdt_pkg::op_t        w_op_q;
	logic [ADDR_BITS-1:0] w_addr_q;
	logic [TB-1:0]        w_rtime_q;
	logic [TB-1:0]        w_ctime_q;
	etdt_pkg::err_t       err_q;
	logic                 wake_q;

	// Table storage.
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [ADDR_BITS-1:0]     mem_addr [TABLE_ENTRIES];
	logic [TB-1:0]            mem_time [TABLE_ENTRIES];

	// Scan read stage.
	logic [IDX_W-1:0]     scan_idx_q;
	logic                 live_s1;
	logic [IDX_W-1:0]     rd_idx_s1;
	logic                 rd_valid_s1;
	logic [ADDR_BITS-1:0] rd_addr_s1;
	logic [TB-1:0]        rd_time_s1;

	// Scan accumulators.
	logic                 hit_q;
	logic [IDX_W-1:0]     hit_idx_q;
	logic                 free_q;
	logic [IDX_W-1:0]     free_idx_q;
	logic                 bfound_q;
	logic [IDX_W-1:0]     best_idx_q;
	logic [ADDR_BITS-1:0] best_addr_q;
	logic [TB-1:0]        best_time_q;

	// Earliest entry of the table.
	logic                 known_q;
	logic [ADDR_BITS-1:0] e_addr_q;
	logic [TB-1:0]        e_time_q;

	// Output register.
	logic                 out_valid_q;
	logic                 out_has_q;
	logic                 out_ready_q;
	logic [ADDR_BITS-1:0] out_addr_q;
	logic                 out_wake_q;
	etdt_pkg::err_t       out_err_q;

	logic match;
	logic consider;
	logic arm_ok;
	logic new_wins;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= etdt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and control strobes.
	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		issue    = 1'b0;
		commit   = 1'b0;
		out_load = 1'b0;
		case (state_q)
			etdt_pkg::ST_IDLE: begin
				if (!fifo_empty) begin
					pop = 1'b1;
					if (in_cls.op == etdt_pkg::OP_QUERY || in_cls.misaligned) begin
						state_d = etdt_pkg::ST_RESULT;
					end else begin
						state_d = etdt_pkg::ST_SCAN;
					end
				end
			end
			etdt_pkg::ST_SCAN: begin
				issue = 1'b1;
				if (scan_idx_q == LAST_IDX) begin
					state_d = etdt_pkg::ST_DRAIN;
				end
			end
			etdt_pkg::ST_DRAIN: begin
				state_d = etdt_pkg::ST_COMMIT;
			end
			etdt_pkg::ST_COMMIT: begin
				commit  = 1'b1;
				state_d = etdt_pkg::ST_RESULT;
			end
			etdt_pkg::ST_RESULT: begin
				if (!out_valid_q || rsp.ready) begin
					out_load = 1'b1;
					state_d  = etdt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = etdt_pkg::ST_IDLE;
			end
		endcase
	end

	// Request registers, loaded when a request leaves the queue.
	always_ff @(posedge clk) begin
		if (pop) begin
			w_op_q    <= in_cls.op;
			w_addr_q  <= in_addr;
			w_rtime_q <= in_rtime;
			w_ctime_q <= in_ctime;
		end
	end

	// Scan address counter and read-stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q  <= '0;
			live_s1     <= 1'b0;
			rd_idx_s1   <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			live_s1 <= issue;
			if (pop) begin
				scan_idx_q <= '0;
			end else if (issue) begin
				scan_idx_q  <= scan_idx_q + 1'b1;
				rd_idx_s1   <= scan_idx_q;
				rd_valid_s1 <= valid_q[scan_idx_q];
			end
		end
	end

	// Slot memories: one write port for arms, one registered read port for the scan.
	always_ff @(posedge clk) begin
		if (commit && arm_ok) begin
			mem_addr[free_idx_q] <= w_addr_q;
			mem_time[free_idx_q] <= w_rtime_q;
		end
		if (issue) begin
			rd_addr_s1 <= mem_addr[scan_idx_q];
			rd_time_s1 <= mem_time[scan_idx_q];
		end
	end

	// Compare the slot just read. A slot about to be disarmed is left out of the
	// minimum; addresses in the table are unique, so a match marks only that slot.
	always_comb begin
		match    = rd_valid_s1 && (rd_addr_s1 == w_addr_q);
		consider = rd_valid_s1 && !(match && (w_op_q == etdt_pkg::OP_DISARM));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q      <= 1'b0;
			hit_idx_q  <= '0;
			free_q     <= 1'b0;
			free_idx_q <= '0;
			bfound_q   <= 1'b0;
			best_idx_q <= '0;
		end else if (pop) begin
			hit_q    <= 1'b0;
			free_q   <= 1'b0;
			bfound_q <= 1'b0;
		end else if (live_s1) begin
			if (match) begin
				hit_q     <= 1'b1;
				hit_idx_q <= rd_idx_s1;
			end
			if (!rd_valid_s1 && !free_q) begin
				free_q     <= 1'b1;
				free_idx_q <= rd_idx_s1;
			end
			if (consider && (!bfound_q || rd_time_s1 < best_time_q)) begin
				bfound_q   <= 1'b1;
				best_idx_q <= rd_idx_s1;
			end
		end
	end

	// Address and time of the best slot so far.
	always_ff @(posedge clk) begin
		if (live_s1 && consider && (!bfound_q || rd_time_s1 < best_time_q)) begin
			best_addr_q <= rd_addr_s1;
			best_time_q <= rd_time_s1;
		end
	end

	// A new entry becomes the earliest if no entry remains, if it is strictly earlier,
	// or if it is equal and in a lower slot than the best remaining entry.
	always_comb begin
		arm_ok   = (w_op_q == etdt_pkg::OP_ARM) && !hit_q && free_q;
		new_wins = !bfound_q || (w_rtime_q < best_time_q)
			|| ((w_rtime_q == best_time_q) && (free_idx_q < best_idx_q));
	end

	// Valid bits, error code, wake flag and the earliest entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			known_q <= 1'b0;
			err_q   <= etdt_pkg::ERR_OK;
			wake_q  <= 1'b0;
		end else if (pop) begin
			err_q  <= in_cls.misaligned ? etdt_pkg::ERR_MISALIGNED : etdt_pkg::ERR_OK;
			wake_q <= 1'b0;
		end else if (commit) begin
			known_q <= bfound_q || arm_ok;
			wake_q  <= arm_ok;
			if (w_op_q == etdt_pkg::OP_ARM) begin
				if (hit_q) begin
					err_q <= etdt_pkg::ERR_ARMED;
				end else if (!free_q) begin
					err_q <= etdt_pkg::ERR_FULL;
				end else begin
					valid_q[free_idx_q] <= 1'b1;
				end
			end else begin
				if (hit_q) begin
					valid_q[hit_idx_q] <= 1'b0;
				end else begin
					err_q <= etdt_pkg::ERR_NOT_ARMED;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			if (arm_ok && new_wins) begin
				e_addr_q <= w_addr_q;
				e_time_q <= w_rtime_q;
			end else begin
				e_addr_q <= best_addr_q;
				e_time_q <= best_time_q;
			end
		end
	end

	// Response register: holds a finished result until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_has_q   <= known_q;
			out_ready_q <= known_q && (w_ctime_q >= e_time_q);
			out_addr_q  <= known_q ? e_addr_q : '0;
			out_wake_q  <= wake_q;
			out_err_q   <= err_q;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.has_entry    = out_has_q;
	assign rsp.is_ready     = out_ready_q;
	assign rsp.next_address = out_addr_q;
	assign rsp.wake_request = out_wake_q;
	assign rsp.error_code   = out_err_q;

endmodule

// File: src/earliest_deadline_timer_table.sv
// ----------------------------------------------------------------------------
// earliest_deadline_timer_table
// Table of line addresses with ready times that tracks the earliest entry.
//
//   Port      Dir   Handshake      Beat
//   req       in    valid/ready    one arm, disarm or query request
//   rsp       out   valid/ready    one result per request
//   cfg_we    in    write enable   line offset register, taken each edge
//
// A query, or an arm or disarm with a misaligned address, goes from the idle
// state to the result state. An arm or disarm passes the scan, drain and
// commit states; the scan reads one slot per cycle through the single read
// port of the slot memories. A two-entry queue takes requests while the engine
// is busy, and the response register holds a result while the sink stalls.
// Reset clears all slot valid bits at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module earliest_deadline_timer_table #(
	parameter int TABLE_ENTRIES = 16,
	parameter int ADDR_BITS     = 48
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [etdt_pkg::OFF_BITS-1:0] cfg_data,
	etdt_req_if.sink                      req,
	etdt_rsp_if.source                    rsp
);

	localparam int WORD_BITS = $bits(etdt_pkg::cls_t) + ADDR_BITS + 2 * etdt_pkg::TIME_BITS;

	logic                 push;
	logic [WORD_BITS-1:0] push_data;
	logic                 fifo_full;
	logic                 pop;
	logic [WORD_BITS-1:0] pop_data;
	logic                 fifo_empty;

	// Front end: register, decode and alignment check.
	etdt_front #(
		.ADDR_BITS (ADDR_BITS),
		.WORD_BITS (WORD_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.req       (req),
		.fifo_full (fifo_full),
		.push      (push),
		.push_data (push_data)
	);

	// Request queue.
	etdt_fifo #(
		.WIDTH (WORD_BITS)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (fifo_full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (fifo_empty)
	);

	// Table engine and response register.
	etdt_back #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.ADDR_BITS     (ADDR_BITS),
		.WORD_BITS     (WORD_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.fifo_empty (fifo_empty),
		.pop_data   (pop_data),
		.pop        (pop),
		.rsp        (rsp)
	);

endmodule
